// ===== rtl/lerc_pkg.sv =====
// shared constants, types and the raised-cosine gain table for the loop edge fade
package lerc_pkg;

  localparam int MaxLoop   = 1048576;
  localparam int GainDepth = 1024;

  localparam int RegW    = 21;
  localparam int PosW    = 20;
  localparam int SmpW    = 24;
  localparam int GainFrac = 16;
  localparam int GainW   = GainFrac + 1;
  localparam int ProdW   = SmpW + GainW + 1;
  localparam int CfgIdxW = 1;

  localparam logic [CfgIdxW-1:0] REG_LOOP_LENGTH = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] REG_FADE_LENGTH = CfgIdxW'(1);

  localparam logic [RegW-1:0] LOOP_LENGTH_RESET = RegW'(0);
  localparam logic [RegW-1:0] FADE_LENGTH_RESET = RegW'(48);

  localparam int KW    = $clog2(GainDepth);
  localparam int LenW  = $clog2(MaxLoop + 1);
  localparam int FadeW = LenW - 1;
  localparam int CmpW  = (PosW > LenW) ? PosW : LenW;
  localparam int NumW  = $clog2(MaxLoop) + KW;
  localparam int DenW  = LenW;

  // start accepted to done strobe, in clock edges
  localparam int Latency = KW + 6;

  localparam logic [GainW-1:0] GAIN_ONE = GainW'(1) << GainFrac;

  typedef struct packed {
    logic                   in_region;
    logic signed [SmpW-1:0] left;
    logic signed [SmpW-1:0] right;
  } lane_t;

  typedef logic [GainW-1:0] gain_tab_t [GainDepth];

  // sin^2 of the table angle, Q30 taylor series squared down to Q1.16
  function automatic logic [GainW-1:0] gain_direct(input int unsigned k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t3;
    logic [63:0] t5;
    logic [63:0] t7;
    logic [63:0] t9;
    logic [63:0] s;
    logic [63:0] s2;
    x  = (64'd3373259426 * 64'(k)) / 64'(2 * (GainDepth - 1));
    x2 = (x * x) >> 30;
    t3 = ((x * x2) >> 30) / 64'd6;
    t5 = ((t3 * x2) >> 30) / 64'd20;
    t7 = ((t5 * x2) >> 30) / 64'd42;
    t9 = ((t7 * x2) >> 30) / 64'd72;
    s  = x - t3 + t5 - t7 + t9;
    s2 = (s * s) >> 30;
    return GainW'((s2 + 64'd8192) >> 14);
  endfunction

  function automatic gain_tab_t build_gain_tab();
    gain_tab_t t;
    for (int k = 0; k < GainDepth; k++) begin
      if (k <= (GainDepth - 1) / 2) begin
        t[k] = gain_direct(k);
      end else begin
        t[k] = GAIN_ONE - gain_direct(GainDepth - 1 - k);
      end
    end
    return t;
  endfunction

  localparam gain_tab_t GAIN_TAB = build_gain_tab();

endpackage

// ===== rtl/lerc_div.sv =====
// pipelined restoring divider, one quotient bit per stage, carries a lane tag
module lerc_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic [lerc_pkg::NumW-1:0] in_num,
  input  logic [lerc_pkg::DenW-1:0] in_den,
  input  lerc_pkg::lane_t           in_tag,
  output logic                      out_valid,
  output logic [lerc_pkg::KW-1:0]   out_quo,
  output lerc_pkg::lane_t           out_tag
);
  import lerc_pkg::*;

  logic [KW:0]     vld_s;
  logic [NumW-1:0] rem_s [KW+1];
  logic [DenW-1:0] den_s [KW+1];
  logic [KW-1:0]   quo_s [KW+1];
  lane_t           tag_s [KW+1];

  assign vld_s[0] = in_valid;
  assign rem_s[0] = in_num;
  assign den_s[0] = in_den;
  assign quo_s[0] = '0;
  assign tag_s[0] = in_tag;

  for (genvar g = 0; g < KW; g++) begin : g_stage
    localparam int B = KW - 1 - g;
    logic [NumW-1:0] sub;
    logic            take;

    assign sub  = NumW'(den_s[g]) << B;
    assign take = rem_s[g] >= sub;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_s[g+1] <= 1'b0;
      end else begin
        vld_s[g+1] <= vld_s[g];
      end
    end

    always_ff @(posedge clk) begin
      rem_s[g+1] <= take ? (rem_s[g] - sub) : rem_s[g];
      quo_s[g+1] <= quo_s[g] | (KW'(take) << B);
      den_s[g+1] <= den_s[g];
      tag_s[g+1] <= tag_s[g];
    end
  end

  assign out_valid = vld_s[KW];
  assign out_quo   = quo_s[KW];
  assign out_tag   = tag_s[KW];

endmodule

// ===== rtl/loop_edge_raised_cosine_fade_core.sv =====
// loop edge raised-cosine fade: stereo pair scaled by a fade-in / fade-out envelope
//
//  channel | signals                                      | handshake
//  --------+----------------------------------------------+----------------------------------
//  in      | position, sample_left, sample_right          | taken when start && !busy
//  out     | faded_left, faded_right                      | done pulse, one cycle, no backpressure
//  cfg     | cfg_index, cfg_data                          | written when cfg_valid && cfg_ready
//
// one pair per clock while busy is low; each pair passes the input, region, dividend,
// divider, gain lookup, scale and output registers; the divider takes one quotient bit per stage
// busy is high after reset and after every config write while the clamped fade
// bounds settle; cfg_ready is always high
// the output side never stalls, so the pipeline only moves forward
module loop_edge_raised_cosine_fade_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [lerc_pkg::PosW-1:0]        position,
  input  logic signed [lerc_pkg::SmpW-1:0] sample_left,
  input  logic signed [lerc_pkg::SmpW-1:0] sample_right,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [lerc_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [lerc_pkg::RegW-1:0]        cfg_data,
  output logic                             done,
  output logic signed [lerc_pkg::SmpW-1:0] faded_left,
  output logic signed [lerc_pkg::SmpW-1:0] faded_right
);
  import lerc_pkg::*;

  logic [RegW-1:0] loop_length;
  logic [RegW-1:0] fade_length;
  logic [1:0]      settle;

  logic [LenW-1:0]  len_clamped;
  logic [FadeW-1:0] half_len;
  logic [LenW-1:0]  eff_len;
  logic [FadeW-1:0] eff_fade;
  logic [LenW-1:0]  tail_start;
  logic [FadeW-1:0] fade_m1;
  logic             fading;
  logic             fade_one;

  logic                   s1_valid;
  logic [PosW-1:0]        s1_pos;
  logic signed [SmpW-1:0] s1_left;
  logic signed [SmpW-1:0] s1_right;

  logic            in_loop;
  logic            head;
  logic            tail;
  logic [LenW-1:0] back_off;

  logic             s2_valid;
  logic [FadeW-1:0] s2_idx;
  lane_t            s2_tag;

  logic            s3_valid;
  logic [NumW-1:0] s3_num;
  lane_t           s3_tag;

  logic          q_valid;
  logic [KW-1:0] q_quo;
  lane_t         q_tag;

  logic                   g_valid;
  logic [GainW-1:0]       gain;
  logic signed [SmpW-1:0] g_left;
  logic signed [SmpW-1:0] g_right;

  logic                    m_valid;
  logic signed [ProdW-1:0] prod_l;
  logic signed [ProdW-1:0] prod_r;
  logic signed [ProdW-1:0] rnd_l;
  logic signed [ProdW-1:0] rnd_r;

  assign cfg_ready = 1'b1;
  assign busy      = |settle;

  always_ff @(posedge clk) begin
    if (rst) begin
      loop_length <= LOOP_LENGTH_RESET;
      fade_length <= FADE_LENGTH_RESET;
      settle      <= 2'b11;
    end else begin
      if (cfg_valid && cfg_ready) begin
        settle <= 2'b11;
        case (cfg_index)
          REG_LOOP_LENGTH: loop_length <= cfg_data;
          REG_FADE_LENGTH: fade_length <= cfg_data;
          default: ;
        endcase
      end else begin
        settle <= {1'b0, settle[1]};
      end
    end
  end

  // clamped loop and fade bounds, static between config writes
  always_comb begin
    len_clamped = (32'(loop_length) > 32'(MaxLoop)) ? LenW'(MaxLoop) : LenW'(loop_length);
    half_len    = len_clamped[LenW-1:1];
  end

  always_ff @(posedge clk) begin
    eff_len    <= len_clamped;
    eff_fade   <= (32'(fade_length) > 32'(half_len)) ? half_len : FadeW'(fade_length);
    tail_start <= eff_len - LenW'(eff_fade);
    fade_m1    <= eff_fade - FadeW'(1);
    fading     <= (eff_len != '0) && (eff_fade != '0);
    fade_one   <= eff_fade == FadeW'(1);
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    s1_pos   <= position;
    s1_left  <= sample_left;
    s1_right <= sample_right;
  end

  // region decision and offset into the fade
  always_comb begin
    in_loop  = fading && (CmpW'(s1_pos) < CmpW'(eff_len));
    head     = CmpW'(s1_pos) < CmpW'(eff_fade);
    tail     = CmpW'(s1_pos) >= CmpW'(tail_start);
    back_off = eff_len - LenW'(1) - LenW'(s1_pos);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s2_idx           <= head ? FadeW'(s1_pos) : back_off[FadeW-1:0];
    s2_tag.in_region <= in_loop && (head || tail);
    s2_tag.left      <= s1_left;
    s2_tag.right     <= s1_right;
  end

  // dividend 2*i*(depth-1) + (F-1), divisor 2*(F-1): index rounded half up
  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    s3_num <= NumW'(s2_idx) * NumW'(2 * (GainDepth - 1)) + NumW'(fade_m1);
    s3_tag <= s2_tag;
  end

  lerc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s3_valid),
    .in_num    (s3_num),
    .in_den    ({fade_m1, 1'b0}),
    .in_tag    (s3_tag),
    .out_valid (q_valid),
    .out_quo   (q_quo),
    .out_tag   (q_tag)
  );

  // gain lookup
  always_ff @(posedge clk) begin
    if (rst) begin
      g_valid <= 1'b0;
    end else begin
      g_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!q_tag.in_region) begin
      gain <= GAIN_ONE;
    end else if (fade_one) begin
      gain <= '0;
    end else begin
      gain <= GAIN_TAB[q_quo];
    end
    g_left  <= q_tag.left;
    g_right <= q_tag.right;
  end

  // scale
  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else begin
      m_valid <= g_valid;
    end
  end

  always_ff @(posedge clk) begin
    prod_l <= ProdW'(g_left) * $signed({1'b0, gain});
    prod_r <= ProdW'(g_right) * $signed({1'b0, gain});
  end

  // round half up and drop the fraction
  always_comb begin
    rnd_l = prod_l + (ProdW'(1) <<< (GainFrac - 1));
    rnd_r = prod_r + (ProdW'(1) <<< (GainFrac - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= m_valid;
    end
  end

  always_ff @(posedge clk) begin
    faded_left  <= rnd_l[GainFrac+SmpW-1:GainFrac];
    faded_right <= rnd_r[GainFrac+SmpW-1:GainFrac];
  end

endmodule

// ===== rtl/lerc_chk.sv =====
// port-level checks for the loop edge fade core, bound to the top level
module lerc_chk (
  input logic                             clk,
  input logic                             rst,
  input logic                             start,
  input logic                             busy,
  input logic [lerc_pkg::PosW-1:0]        position,
  input logic signed [lerc_pkg::SmpW-1:0] sample_left,
  input logic signed [lerc_pkg::SmpW-1:0] sample_right,
  input logic                             cfg_valid,
  input logic                             cfg_ready,
  input logic [lerc_pkg::CfgIdxW-1:0]     cfg_index,
  input logic [lerc_pkg::RegW-1:0]        cfg_data,
  input logic                             done,
  input logic signed [lerc_pkg::SmpW-1:0] faded_left,
  input logic signed [lerc_pkg::SmpW-1:0] faded_right
);
  import lerc_pkg::*;

  // every taken item comes out after the fixed latency
  a_item_out: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##Latency done)
    else $error("taken item did not produce a result on time");

  // no result without an item taken the latency before
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, Latency))
    else $error("result without a matching item");

  // a config write holds off items while the bounds settle
  a_cfg_busy: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready |=> busy)
    else $error("item port open right after a config write");

  // a zero left sample stays zero whatever the gain
  a_zero_left: assert property (@(posedge clk) disable iff (rst)
    done && $past(start && !busy && sample_left == '0, Latency) |-> faded_left == '0)
    else $error("zero left sample scaled to nonzero");

endmodule

bind loop_edge_raised_cosine_fade_core lerc_chk u_lerc_chk (.*);
